// ----- rtl/scadpt_pkg.sv -----
package scadpt_pkg;

   // configuration register width and index decode
   localparam int REG_WIDTH       = 31;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAMBDA    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONCAVITY = 2'd2;

   localparam logic [REG_WIDTH-1:0] LAMBDA_RESET    = 31'd65536;
   localparam logic [REG_WIDTH-1:0] STEP_RESET      = 31'd65536;
   localparam logic [REG_WIDTH-1:0] CONCAVITY_RESET = 31'd242483;

   // the scaled magnitude enters the middle-region product as a 64-bit word,
   // multiplied in two 32-bit halves
   localparam int AV_LOW_WIDTH = 64;
   localparam int PROD_SPLIT   = 32;
   localparam int NUM_WIDTH    = AV_LOW_WIDTH + REG_WIDTH;

   typedef enum logic [1:0] {
      RGN_SOFT,
      RGN_MID,
      RGN_PASS,
      RGN_BAD
   } region_type;

   // control that travels with each beat down the pipeline
   typedef struct packed {
      logic       valid;
      logic       neg;
      region_type region;
      logic       zero;
      logic       ovf;
   } ctl_type;

   // programmed registers plus values derived from them
   typedef struct packed {
      logic [REG_WIDTH-1:0] lambda;
      logic [REG_WIDTH-1:0] step;
      logic [REG_WIDTH-1:0] concavity;
      logic [REG_WIDTH-1:0] am1;
      logic [REG_WIDTH-1:0] den;
      logic                 inv;
   } cfg_type;

endpackage

// ----- rtl/scadpt_csr.sv -----
module scadpt_csr
   import scadpt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]       csr_data,
   output cfg_type                    cfg
);

   localparam int SUM_WIDTH = ((FRAC_BITS > REG_WIDTH) ? FRAC_BITS : REG_WIDTH) + 1;
   localparam logic [SUM_WIDTH-1:0] ONE = {{(SUM_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [REG_WIDTH-1:0] lambda_ff;
   logic [REG_WIDTH-1:0] step_ff;
   logic [REG_WIDTH-1:0] concavity_ff;
   logic [REG_WIDTH-1:0] am1_ff;
   logic [REG_WIDTH-1:0] den_ff;
   logic                 inv_ff;
   logic [REG_WIDTH-1:0] am1_in;
   logic [REG_WIDTH-1:0] den_in;
   logic                 inv_in;
   logic [SUM_WIDTH-1:0] sum_one_step;

   // decode register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff    <= LAMBDA_RESET;
         step_ff      <= STEP_RESET;
         concavity_ff <= CONCAVITY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LAMBDA:    lambda_ff    <= csr_data;
            CSR_STEP:      step_ff      <= csr_data;
            CSR_CONCAVITY: concavity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // derive a-1, a-1-t and the step check; used from the second stage on
   always_comb begin
      sum_one_step = ONE + SUM_WIDTH'(step_ff);
      inv_in       = sum_one_step >= SUM_WIDTH'(concavity_ff);
      am1_in       = REG_WIDTH'(SUM_WIDTH'(concavity_ff) - ONE);
      den_in       = REG_WIDTH'(SUM_WIDTH'(concavity_ff) - sum_one_step);
   end

   always_ff @(posedge clock) begin
      am1_ff <= am1_in;
      den_ff <= den_in;
      inv_ff <= inv_in;
   end

   assign cfg.lambda    = lambda_ff;
   assign cfg.step      = step_ff;
   assign cfg.concavity = concavity_ff;
   assign cfg.am1       = am1_ff;
   assign cfg.den       = den_ff;
   assign cfg.inv       = inv_ff;

endmodule

// ----- rtl/scadpt_front.sv -----
module scadpt_front
   import scadpt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_coef,
   input  cfg_type               cfg,
   output ctl_type               ctl_out,
   output logic [DATA_WIDTH-1:0] side_out,
   output logic [NUM_WIDTH-1:0]  num_out
);

   localparam int AVW = DATA_WIDTH + FRAC_BITS;
   localparam int PW  = 2 * REG_WIDTH;
   localparam int LSW = REG_WIDTH + FRAC_BITS;
   localparam int T1W = ((LSW > PW) ? LSW : PW) + 1;
   localparam int XW  = (AVW > T1W) ? AVW : T1W;
   localparam int PPW = PROD_SPLIT + REG_WIDTH;

   // stage 1: magnitude and the two config products
   ctl_type               ctl_s1_ff;
   ctl_type               ctl_s1_in;
   logic [DATA_WIDTH-1:0] raw_s1_ff;
   logic [DATA_WIDTH-1:0] absv_s1_ff;
   logic [DATA_WIDTH-1:0] absv_s1_in;
   logic [PW-1:0]         thr_s1_ff;
   logic [PW-1:0]         al_s1_ff;

   always_comb begin
      ctl_s1_in        = '0;
      ctl_s1_in.valid  = in_valid;
      ctl_s1_in.neg    = in_coef[DATA_WIDTH-1];
      ctl_s1_in.region = RGN_PASS;
      absv_s1_in = in_coef[DATA_WIDTH-1] ? (~in_coef + DATA_WIDTH'(1)) : in_coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
      end else begin
         ctl_s1_ff <= ctl_s1_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_s1_ff  <= in_coef;
      absv_s1_ff <= absv_s1_in;
      thr_s1_ff  <= PW'(cfg.lambda) * PW'(cfg.step);
      al_s1_ff   <= PW'(cfg.concavity) * PW'(cfg.lambda);
   end

   // stage 2: classify, soft shrink, and partial products of the middle region
   ctl_type               ctl_s2_ff;
   ctl_type               ctl_s2_in;
   logic [DATA_WIDTH-1:0] raw_s2_ff;
   logic [DATA_WIDTH-1:0] mag_s2_ff;
   logic [DATA_WIDTH-1:0] mag_s2_in;
   logic [PPW-1:0]        pp_lo_s2_ff;
   logic [PPW-1:0]        pp_hi_s2_ff;
   logic [PW-1:0]         pn_lo_s2_ff;
   logic [PW-1:0]         pn_hi_s2_ff;
   logic [AVW-1:0]          av1;
   logic [XW-1:0]           av1_x;
   logic [XW-1:0]           thr1;
   logic [XW-1:0]           soft_diff;
   logic [AV_LOW_WIDTH-1:0] av1_lo;

   always_comb begin
      av1       = {absv_s1_ff, {FRAC_BITS{1'b0}}};
      av1_x     = XW'(av1);
      av1_lo    = AV_LOW_WIDTH'(av1);
      thr1      = XW'({cfg.lambda, {FRAC_BITS{1'b0}}}) + XW'(thr_s1_ff);
      soft_diff = av1_x - XW'(thr_s1_ff);
      mag_s2_in = DATA_WIDTH'(soft_diff >> FRAC_BITS);
      ctl_s2_in = ctl_s1_ff;
      ctl_s2_in.zero = av1_x <= XW'(thr_s1_ff);
      if (cfg.inv) begin
         ctl_s2_in.region = RGN_BAD;
      end else if (av1_x <= thr1) begin
         ctl_s2_in.region = RGN_SOFT;
      end else if (av1_x <= XW'(al_s1_ff)) begin
         ctl_s2_in.region = RGN_MID;
      end else begin
         ctl_s2_in.region = RGN_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s2_ff <= '0;
      end else begin
         ctl_s2_ff <= ctl_s2_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_s2_ff   <= raw_s1_ff;
      mag_s2_ff   <= mag_s2_in;
      pp_lo_s2_ff <= PPW'(av1_lo[PROD_SPLIT-1:0]) * PPW'(cfg.am1);
      pp_hi_s2_ff <= PPW'(av1_lo[AV_LOW_WIDTH-1:PROD_SPLIT]) * PPW'(cfg.am1);
      pn_lo_s2_ff <= PW'(al_s1_ff[REG_WIDTH-1:0]) * PW'(cfg.step);
      pn_hi_s2_ff <= PW'(al_s1_ff[PW-1:REG_WIDTH]) * PW'(cfg.step);
   end

   // stage 3: sum partial products, finish the soft and pass results
   ctl_type               ctl_s3_ff;
   logic [DATA_WIDTH-1:0] side_s3_ff;
   logic [DATA_WIDTH-1:0] side_s3_in;
   logic [NUM_WIDTH-1:0]  pos_s3_ff;
   logic [NUM_WIDTH-1:0]  negp_s3_ff;

   always_comb begin
      if (ctl_s2_ff.region == RGN_SOFT) begin
         if (ctl_s2_ff.zero) begin
            side_s3_in = '0;
         end else if (ctl_s2_ff.neg) begin
            side_s3_in = ~mag_s2_ff + DATA_WIDTH'(1);
         end else begin
            side_s3_in = mag_s2_ff;
         end
      end else begin
         side_s3_in = raw_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s3_ff <= '0;
      end else begin
         ctl_s3_ff <= ctl_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side_s3_ff <= side_s3_in;
      pos_s3_ff  <= NUM_WIDTH'(pp_lo_s2_ff) + (NUM_WIDTH'(pp_hi_s2_ff) << PROD_SPLIT);
      negp_s3_ff <= NUM_WIDTH'(pn_lo_s2_ff) + (NUM_WIDTH'(pn_hi_s2_ff) << REG_WIDTH);
   end

   // stage 4: numerator of the middle region, zero when it does not stay positive
   ctl_type               ctl_s4_ff;
   ctl_type               ctl_s4_in;
   logic [DATA_WIDTH-1:0] side_s4_ff;
   logic [NUM_WIDTH-1:0]  num_s4_ff;
   logic [NUM_WIDTH:0]    num_diff;

   always_comb begin
      num_diff       = {1'b0, pos_s3_ff} - {1'b0, negp_s3_ff};
      ctl_s4_in      = ctl_s3_ff;
      ctl_s4_in.zero = num_diff[NUM_WIDTH] || (num_diff[NUM_WIDTH-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s4_ff <= '0;
      end else begin
         ctl_s4_ff <= ctl_s4_in;
      end
   end

   always_ff @(posedge clock) begin
      side_s4_ff <= side_s3_ff;
      num_s4_ff  <= num_diff[NUM_WIDTH-1:0];
   end

   assign ctl_out  = ctl_s4_ff;
   assign side_out = side_s4_ff;
   assign num_out  = num_s4_ff;

endmodule

// ----- rtl/scadpt_div.sv -----
module scadpt_div
   import scadpt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl_in,
   input  logic [DATA_WIDTH-1:0] side_in,
   input  logic [NUM_WIDTH-1:0]  num_in,
   input  logic [REG_WIDTH-1:0]  den,
   output ctl_type               ctl_out,
   output logic [DATA_WIDTH-1:0] side_out,
   output logic [DATA_WIDTH-1:0] quot_out
);

   localparam int DVW = REG_WIDTH + FRAC_BITS;
   localparam int CW  = (NUM_WIDTH > DVW + DATA_WIDTH) ? NUM_WIDTH : DVW + DATA_WIDTH;

   ctl_type               ctl_ff  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] side_ff [DATA_WIDTH+1];
   logic [NUM_WIDTH-1:0]  rem_ff  [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] quot_ff [DATA_WIDTH+1];
   logic [CW-1:0]         dvs;
   ctl_type               ctl0_in;

   // divisor is (a-1-t) scaled by one
   assign dvs = CW'({den, {FRAC_BITS{1'b0}}});

   // entry stage: flag quotients that do not fit the data width
   always_comb begin
      ctl0_in     = ctl_in;
      ctl0_in.ovf = CW'(num_in) >= (dvs << DATA_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      rem_ff[0]  <= num_in;
      quot_ff[0] <= '0;
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_bit
      localparam int BIT = DATA_WIDTH - 1 - k;

      logic [CW-1:0]         dvs_sh;
      logic                  take;
      logic [NUM_WIDTH-1:0]  rem_in;
      logic [DATA_WIDTH-1:0] quot_in;

      always_comb begin
         dvs_sh       = dvs << BIT;
         take         = CW'(rem_ff[k]) >= dvs_sh;
         rem_in       = take ? NUM_WIDTH'(CW'(rem_ff[k]) - dvs_sh) : rem_ff[k];
         quot_in      = quot_ff[k];
         quot_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else begin
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k+1] <= side_ff[k];
         rem_ff[k+1]  <= rem_in;
         quot_ff[k+1] <= quot_in;
      end
   end

   assign ctl_out  = ctl_ff[DATA_WIDTH];
   assign side_out = side_ff[DATA_WIDTH];
   assign quot_out = quot_ff[DATA_WIDTH];

endmodule

// ----- rtl/scad_proximal_threshold.sv -----
// SCAD proximal threshold, one signed fixed-point coefficient per beat. The
// block takes a new coefficient on every clock (busy stays low) and returns
// each result in order, as a one-cycle rsp_valid strobe; the receiver cannot
// stall, so results must be captured when they appear. The quotient of the
// middle region is formed one bit per pipeline stage, behind four stages of
// magnitude, region decision and product forming and ahead of one output
// stage. Registers may be written only while no beat is in flight; an item
// may be started on the cycle after a write.
module scad_proximal_threshold
   import scadpt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [DATA_WIDTH-1:0]      req_coef_in,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_coef_out,
   output logic                       rsp_step_invalid,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [REG_WIDTH-1:0]       csr_data
);

   localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   cfg_type               cfg;
   ctl_type               ctl_front;
   logic [DATA_WIDTH-1:0] side_front;
   logic [NUM_WIDTH-1:0]  num_front;
   ctl_type               ctl_div;
   logic [DATA_WIDTH-1:0] side_div;
   logic [DATA_WIDTH-1:0] quot_div;

   // the pipeline never stalls
   assign busy = 1'b0;

   scadpt_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cfg         (cfg)
   );

   scadpt_front #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start),
      .in_coef (req_coef_in),
      .cfg     (cfg),
      .ctl_out (ctl_front),
      .side_out(side_front),
      .num_out (num_front)
   );

   scadpt_div #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (ctl_front),
      .side_in (side_front),
      .num_in  (num_front),
      .den     (cfg.den),
      .ctl_out (ctl_div),
      .side_out(side_div),
      .quot_out(quot_div)
   );

   // saturate the middle-region quotient, apply the sign, pick the result
   logic [DATA_WIDTH-1:0] lim;
   logic                  sat;
   logic [DATA_WIDTH-1:0] mid_val;
   logic [DATA_WIDTH-1:0] coef_out_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_coef_out_ff;
   logic                  rsp_step_invalid_ff;

   always_comb begin
      lim = ctl_div.neg ? MAX_NEG : MAX_POS;
      sat = ctl_div.ovf || (quot_div > lim);
      if (ctl_div.zero) begin
         mid_val = '0;
      end else if (sat) begin
         mid_val = lim;
      end else if (ctl_div.neg) begin
         mid_val = ~quot_div + DATA_WIDTH'(1);
      end else begin
         mid_val = quot_div;
      end
      coef_out_in = (ctl_div.region == RGN_MID) ? mid_val : side_div;
   end

   // hold each result for one cycle on the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_div.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_coef_out_ff     <= coef_out_in;
      rsp_step_invalid_ff <= ctl_div.region == RGN_BAD;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coef_out     = rsp_coef_out_ff;
   assign rsp_step_invalid = rsp_step_invalid_ff;

endmodule

// ----- tb/sv/tb_scad_proximal_threshold.sv -----
module tb_scad_proximal_threshold;
   import scadpt_pkg::*;

   localparam int DW        = 32;
   localparam int FB        = 16;
   localparam int LIMIT     = 300000;
   localparam int ONE_CODE  = 1 << FB;

   // index past the end of the register map; writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic [DW-1:0] coef;
      logic          flag;
   } coef_result_type;

   // Tracks the register file, predicts each coefficient and holds the
   // outstanding results in issue order.
   class prox_ledger;
      logic [REG_WIDTH-1:0] lambda_q;
      logic [REG_WIDTH-1:0] step_q;
      logic [REG_WIDTH-1:0] shape_q;
      coef_result_type      pending[$];
      int                   region_hits[4];
      int                   failures;
      int                   coefs_seen;

      function new();
         lambda_q   = LAMBDA_RESET;
         step_q     = STEP_RESET;
         shape_q    = CONCAVITY_RESET;
         failures   = 0;
         coefs_seen = 0;
         foreach (region_hits[i]) region_hits[i] = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [REG_WIDTH-1:0] data);
         case (idx)
            CSR_LAMBDA:    lambda_q = data;
            CSR_STEP:      step_q = data;
            CSR_CONCAVITY: shape_q = data;
            default: ;
         endcase
      endfunction

      // SCAD proximal map on the integer codes, all products kept exact
      function region_type shrink(input logic [DW-1:0] raw, output logic [DW-1:0] res,
                                  output logic flag);
         logic [127:0] lam, stp, shp, one, absv, av1, thr, am1, den;
         logic [127:0] pos, neg_part, quo, lim, mag;
         logic [DW-1:0] mag_code;
         logic          neg;
         lam = {97'b0, lambda_q};
         stp = {97'b0, step_q};
         shp = {97'b0, shape_q};
         one = 128'(ONE_CODE);
         neg = raw[DW-1];
         mag_code = neg ? -raw : raw;
         absv = {96'b0, mag_code};
         flag = 1'b0;
         res = raw;
         // step at or beyond a-1: pass through and flag
         if (stp + one >= shp) begin
            flag = 1'b1;
            return RGN_BAD;
         end
         av1 = absv << FB;
         // inner region: plain soft threshold by lambda*t
         if (av1 <= lam * (one + stp)) begin
            thr = lam * stp;
            mag = (av1 <= thr) ? 128'd0 : (av1 - thr) >> FB;
            res = neg ? -mag[DW-1:0] : mag[DW-1:0];
            return RGN_SOFT;
         end
         // middle region: shrink and rescale in one division
         if (av1 <= shp * lam) begin
            am1 = shp - one;
            den = am1 - stp;
            pos = av1 * am1;
            neg_part = (shp * lam) * stp;
            if (pos <= neg_part) begin
               mag = 128'd0;
            end else begin
               quo = (pos - neg_part) / (one * den);
               lim = neg ? (128'd1 << (DW - 1)) : (128'd1 << (DW - 1)) - 128'd1;
               mag = (quo > lim) ? lim : quo;
            end
            res = neg ? -mag[DW-1:0] : mag[DW-1:0];
            return RGN_MID;
         end
         return RGN_PASS;
      endfunction

      function void note_coef(logic [DW-1:0] coef);
         coef_result_type want;
         region_type      rgn;
         rgn = shrink(coef, want.coef, want.flag);
         region_hits[rgn]++;
         coefs_seen++;
         pending.push_back(want);
      endfunction

      function void check_coef(logic [DW-1:0] coef, logic flag);
         coef_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected beat: coef_out %h step_invalid %b", coef, flag);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (coef !== want.coef) begin
            $error("coef_out mismatch: expected %h actual %h", want.coef, coef);
            failures++;
         end
         if (flag !== want.flag) begin
            $error("step_invalid mismatch: expected %b actual %b", want.flag, flag);
            failures++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [DW-1:0]              req_coef_in = '0;
   logic                       rsp_valid;
   logic [DW-1:0]              rsp_coef_out;
   logic                       rsp_step_invalid;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0]       csr_data = '0;

   prox_ledger  ledger;
   int          burst_left = 1;
   int          settings_count = 1;
   int unsigned cycle_count = 0;

   scad_proximal_threshold #(
      .DATA_WIDTH(DW),
      .FRAC_BITS (FB)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_coef_in     (req_coef_in),
      .rsp_valid       (rsp_valid),
      .rsp_coef_out    (rsp_coef_out),
      .rsp_step_invalid(rsp_step_invalid),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   // check every result beat at the edge that ends its strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) ledger.check_coef(rsp_coef_out, rsp_step_invalid);
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // present one coefficient, hold it until taken, then idle for a random gap (possibly none) at burst ends
   task automatic send_coef(input logic [DW-1:0] value);
      int gap;
      start <= 1'b1;
      req_coef_in <= value;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.note_coef(value);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            start <= 1'b0;
            req_coef_in <= $urandom;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
      end
   endtask

   // stop issuing and wait until every outstanding beat has come back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (ledger.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [REG_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      ledger.set_register(idx, data);
   endtask

   task automatic apply_setting(input logic [REG_WIDTH-1:0] lam,
                                input logic [REG_WIDTH-1:0] stp,
                                input logic [REG_WIDTH-1:0] shp);
      drain_results();
      write_csr(CSR_LAMBDA, lam);
      write_csr(CSR_STEP, stp);
      write_csr(CSR_CONCAVITY, shp);
      csr_write_en <= 1'b0;
      settings_count++;
   endtask

   // random coefficients, half aimed at the region boundaries of the current setting
   task automatic run_random(input int count);
      logic [63:0] b_thr, b_knee, b_outer, m;
      logic [DW-1:0] v;
      int sel;
      for (int n = 0; n < count; n++) begin
         b_thr   = (64'(ledger.lambda_q) * 64'(ledger.step_q)) >> FB;
         b_knee  = (64'(ledger.lambda_q) * (64'(ONE_CODE) + 64'(ledger.step_q))) >> FB;
         b_outer = (64'(ledger.shape_q) * 64'(ledger.lambda_q)) >> FB;
         sel = $urandom_range(0, 9);
         case (sel)
            2:       m = b_thr;
            3, 4:    m = b_knee;
            5, 6:    m = b_outer;
            7:       m = (b_outer > b_knee) ?
                         b_knee + ({$urandom, $urandom} % (b_outer - b_knee + 1)) : b_knee;
            8:       m = 64'($urandom_range(0, 255));
            default: m = 64'($urandom);
         endcase
         // jitter around the aimed point, clamp to the largest magnitude
         if (sel >= 2 && sel <= 6) begin
            m = m + 64'($urandom_range(0, 8));
            m = (m >= 64'd4) ? m - 64'd4 : 64'd0;
         end
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         v = m[DW-1:0];
         if ($urandom_range(0, 1) == 1) v = -v;
         if (sel == 9) begin
            case ($urandom_range(0, 5))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'h8000_0001;
               3: v = 32'h0000_0000;
               4: v = 32'h0000_0001;
               default: v = 32'hFFFF_FFFF;
            endcase
         end else if (sel <= 1) begin
            v = $urandom;
         end
         send_coef(v);
      end
   endtask

   initial begin
      logic [DW-1:0] probes[$];
      logic [31:0]   r_lam, r_stp, r_shp;
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting (lambda 1, t 1, a 3.7): zero, LSBs, each boundary, extremes
      probes = {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                32'h0001_0001, 32'hFFFE_8000, 32'h0002_0000, 32'h0002_0001,
                32'hFFFD_0000, 32'h0003_B333, 32'h0003_B334, 32'hFFFC_4CCD,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001};
      foreach (probes[i]) send_coef(probes[i]);
      run_random(150);

      apply_setting(31'd65536, 31'd32768, 31'd242483);
      run_random(150);

      // divisor of one code: steepest middle region, most negative input at the limit
      apply_setting(31'h4000_0000, 31'd65535, 31'd131072);
      probes = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_C000, 32'h7FFF_C001};
      foreach (probes[i]) send_coef(probes[i]);
      run_random(100);

      // lowest legal setting: lambda and t zero, a just above one
      apply_setting(31'd0, 31'd0, 31'd65537);
      run_random(100);

      // largest lambda and a, no step
      apply_setting(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
      run_random(100);

      // a at one: every coefficient flagged and passed through
      apply_setting(31'd65536, 31'd0, 31'd65536);
      send_coef(32'h8000_0000);
      send_coef(32'h1234_5678);
      run_random(30);

      // a write past the register map must change nothing
      drain_results();
      write_csr(CSR_UNMAPPED, 31'($urandom));
      csr_write_en <= 1'b0;
      run_random(20);

      // largest step, and a step exactly at a-1
      apply_setting(31'd65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      run_random(25);
      apply_setting(31'd65536, 31'd65536, 31'd131072);
      run_random(25);

      // random settings across scales
      for (int k = 0; k < 4; k++) begin
         r_lam = $urandom >> $urandom_range(1, 20);
         r_stp = $urandom >> $urandom_range(6, 28);
         r_shp = r_stp + 32'd65536 + ($urandom >> $urandom_range(8, 30));
         apply_setting(r_lam[30:0], r_stp[30:0], r_shp[30:0]);
         run_random(100);
      end

      // let every beat return, then watch for strays
      drain_results();
      repeat (DW + 10) @(posedge clock);
      if (ledger.pending.size() != 0) begin
         $error("%0d results never arrived", ledger.pending.size());
         ledger.failures++;
      end

      $display("run covered %0d coefficients under %0d register settings",
               ledger.coefs_seen, settings_count);
      $display("regions hit: soft %0d, middle %0d, outer %0d, flagged %0d",
               ledger.region_hits[RGN_SOFT], ledger.region_hits[RGN_MID],
               ledger.region_hits[RGN_PASS], ledger.region_hits[RGN_BAD]);
      if (ledger.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/scadpt_pkg.sv
rtl/scadpt_csr.sv
rtl/scadpt_front.sv
rtl/scadpt_div.sv
rtl/scad_proximal_threshold.sv
tb/sv/tb_scad_proximal_threshold.sv
